@@ hw/rtl/sat_trail_decision_hint_tracker_core_macros.svh @@
// ----------------------------------------------------------------------------
// sat_trail_decision_hint_tracker_core_macros
// assertion macros used by the tracker checker
// ----------------------------------------------------------------------------
`ifndef SAT_TRAIL_DECISION_HINT_TRACKER_CORE_MACROS_SVH
`define SAT_TRAIL_DECISION_HINT_TRACKER_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SDHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SDHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sdht_pkg.sv @@
// ----------------------------------------------------------------------------
// sdht_pkg
// field widths, command and status codes, result type of the trail tracker
// ----------------------------------------------------------------------------
package sdht_pkg;

    localparam int CMD_W = 3;
    localparam int VAR_W = 10;
    localparam int LVL_W = 10;
    localparam int ST_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_HINT      = 3'd0,
        CMD_ASSIGN    = 3'd1,
        CMD_NEW_LEVEL = 3'd2,
        CMD_BACKTRACK = 3'd3,
        CMD_DECIDE    = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    localparam logic [1:0] AV_OPEN  = 2'd0;
    localparam logic [1:0] AV_TRUE  = 2'd1;
    localparam logic [1:0] AV_FALSE = 2'd2;

    typedef struct packed {
        logic             dvalid;
        logic [VAR_W-1:0] dvar;
        logic             dneg;
        logic [ST_W-1:0]  status;
    } t_result;

endpackage

@@ hw/rtl/sat_trail_decision_hint_tracker_core.sv @@
// ----------------------------------------------------------------------------
// sat_trail_decision_hint_tracker_core
// assignment trail with decision levels and a queue of hinted decisions
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   in       | i_in_valid / o_in_ready    | cmd, lit_var, lit_neg, target_level
//   out      | o_out_valid / i_out_ready  | decision_valid/var/neg, status
//
// hint, assign, new level and unknown commands finish in the execute state, as does
// backtrack when the level is not below the count; else backtrack unwinds the trail
//   entry by entry, clearing each unwound variable in the table
// decide pops hints until it finds one whose variable is open or the queue is empty
// after reset a clearing pass over min(NUM_VARS, 1024) entries empties the table
// a finished item waits in the output register; the next item is taken meanwhile
// ----------------------------------------------------------------------------
module sat_trail_decision_hint_tracker_core #(
    parameter int NUM_VARS    = 1024,
    parameter int LEVEL_DEPTH = 1024,
    parameter int HINT_DEPTH  = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sdht_pkg::CMD_W-1:0]  i_cmd,
    input  logic [sdht_pkg::VAR_W-1:0]  i_lit_var,
    input  logic                        i_lit_neg,
    input  logic [sdht_pkg::LVL_W-1:0]  i_target_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_decision_valid,
    output logic [sdht_pkg::VAR_W-1:0]  o_decision_var,
    output logic                        o_decision_neg,
    output logic [sdht_pkg::ST_W-1:0]   o_status
);
    import sdht_pkg::*;

    localparam int AT_DEPTH = (NUM_VARS < (1 << VAR_W)) ? NUM_VARS : (1 << VAR_W);
    localparam int AW       = $clog2(AT_DEPTH);
    localparam int TL_W     = $clog2(AT_DEPTH + 1);
    localparam int LW       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int LC_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int HW       = (HINT_DEPTH > 1) ? $clog2(HINT_DEPTH) : 1;
    localparam int HC_W     = $clog2(HINT_DEPTH + 1);
    localparam int HS_W     = HC_W + 1;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_EXEC     = 8'b0000_0100,
        S_UNWIND   = 8'b0000_1000,
        S_DEC_HEAD = 8'b0001_0000,
        S_DEC_VAR  = 8'b0010_0000,
        S_DEC_CHK  = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } t_state;

    // memories
    logic [1:0]      r_tab_mem [AT_DEPTH];
    logic [AW-1:0]   r_trl_mem [AT_DEPTH];
    logic [TL_W-1:0] r_lvm_mem [LEVEL_DEPTH];
    logic [VAR_W:0]  r_hq_mem  [HINT_DEPTH];

    logic [1:0]      r_tab_rd;
    logic [AW-1:0]   r_trl_rd;
    logic [TL_W-1:0] r_lvm_rd;
    logic [VAR_W:0]  r_hq_rd;

    logic            tab_we, tab_re;
    logic [AW-1:0]   tab_wa, tab_ra;
    logic [1:0]      tab_wd;
    logic            trl_we, trl_re;
    logic [AW-1:0]   trl_wa, trl_ra, trl_wd;
    logic            lvm_we, lvm_re;
    logic [LW-1:0]   lvm_wa, lvm_ra;
    logic [TL_W-1:0] lvm_wd;
    logic            hq_we, hq_re;
    logic [HW-1:0]   hq_wa, hq_ra;
    logic [VAR_W:0]  hq_wd;

    // control and payload registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [VAR_W-1:0] r_var, n_var;
    logic             r_neg, n_neg;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [TL_W-1:0]  r_trail_len, n_trail_len;
    logic [LC_W-1:0]  r_level_count, n_level_count;
    logic [HW-1:0]    r_hint_head, n_hint_head;
    logic [HC_W-1:0]  r_hint_count, n_hint_count;
    logic [TL_W-1:0]  r_keep, n_keep;
    logic             r_pend, n_pend;
    t_result          r_res, n_res;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             fin;
    t_result          fin_res;
    logic             slot_free;
    logic             usable;
    logic [1:0]       lit_val;
    logic [HS_W-1:0]  hsum, hwrap;
    logic [HW-1:0]    hint_tail;
    logic             bt_go;

    assign slot_free = !r_out_valid || i_out_ready;
    assign usable    = (r_var != '0) && (32'(r_var) < NUM_VARS);
    assign lit_val   = r_neg ? AV_FALSE : AV_TRUE;
    assign hsum      = HS_W'(r_hint_head) + HS_W'(r_hint_count);
    assign hwrap     = (hsum >= HS_W'(HINT_DEPTH)) ? hsum - HS_W'(HINT_DEPTH) : hsum;
    assign hint_tail = HW'(hwrap);
    assign bt_go     = 32'(r_lvl) < 32'(r_level_count);

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab_mem[tab_wa] <= tab_wd;
        if (tab_re) r_tab_rd <= r_tab_mem[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (trl_we) r_trl_mem[trl_wa] <= trl_wd;
        if (trl_re) r_trl_rd <= r_trl_mem[trl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lvm_we) r_lvm_mem[lvm_wa] <= lvm_wd;
        if (lvm_re) r_lvm_rd <= r_lvm_mem[lvm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hq_we) r_hq_mem[hq_wa] <= hq_wd;
        if (hq_re) r_hq_rd <= r_hq_mem[hq_ra];
    end

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_cmd         = r_cmd;
        n_var         = r_var;
        n_neg         = r_neg;
        n_lvl         = r_lvl;
        n_trail_len   = r_trail_len;
        n_level_count = r_level_count;
        n_hint_head   = r_hint_head;
        n_hint_count  = r_hint_count;
        n_keep        = r_keep;
        n_pend        = r_pend;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_out_ready;

        tab_we = 1'b0; tab_wa = '0; tab_wd = AV_OPEN; tab_re = 1'b0; tab_ra = '0;
        trl_we = 1'b0; trl_wa = '0; trl_wd = '0;      trl_re = 1'b0; trl_ra = '0;
        lvm_we = 1'b0; lvm_wa = '0; lvm_wd = '0;      lvm_re = 1'b0; lvm_ra = '0;
        hq_we  = 1'b0; hq_wa  = '0; hq_wd  = '0;      hq_re  = 1'b0; hq_ra  = '0;

        fin     = 1'b0;
        fin_res = '0;

        unique case (r_state)
            S_CLEAR: begin
                tab_we = 1'b1;
                tab_wa = r_clr;
                n_clr  = r_clr + 1'b1;
                if (r_clr == AW'(AT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_var   = i_lit_var;
                    n_neg   = i_lit_neg;
                    n_lvl   = i_target_level;
                    tab_re  = 1'b1;
                    tab_ra  = AW'(i_lit_var);
                    lvm_re  = 1'b1;
                    lvm_ra  = LW'(i_target_level);
                    n_state = (i_cmd == CMD_DECIDE) ? S_DEC_HEAD : S_EXEC;
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                unique case (r_cmd)
                    CMD_HINT: begin
                        if (usable) begin
                            if (r_hint_count == HC_W'(HINT_DEPTH)) begin
                                fin_res.status = ST_FULL;
                            end else begin
                                hq_we        = 1'b1;
                                hq_wa        = hint_tail;
                                hq_wd        = {r_var, r_neg};
                                n_hint_count = r_hint_count + 1'b1;
                            end
                        end
                    end
                    CMD_ASSIGN: begin
                        if (usable) begin
                            if (r_tab_rd != AV_OPEN) begin
                                fin_res.status = (r_tab_rd == lit_val) ? ST_OK : ST_CONFLICT;
                            end else if (r_trail_len == TL_W'(AT_DEPTH)) begin
                                fin_res.status = ST_FULL;
                            end else begin
                                tab_we      = 1'b1;
                                tab_wa      = AW'(r_var);
                                tab_wd      = lit_val;
                                trl_we      = 1'b1;
                                trl_wa      = AW'(r_trail_len);
                                trl_wd      = AW'(r_var);
                                n_trail_len = r_trail_len + 1'b1;
                            end
                        end
                    end
                    CMD_NEW_LEVEL: begin
                        if (r_level_count == LC_W'(LEVEL_DEPTH)) begin
                            fin_res.status = ST_FULL;
                        end else begin
                            lvm_we        = 1'b1;
                            lvm_wa        = LW'(r_level_count);
                            lvm_wd        = r_trail_len;
                            n_level_count = r_level_count + 1'b1;
                        end
                    end
                    CMD_BACKTRACK: begin
                        if (bt_go) begin
                            fin           = 1'b0;
                            n_level_count = LC_W'(r_lvl);
                            n_keep        = r_lvm_rd;
                            n_pend        = 1'b0;
                            n_state       = S_UNWIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UNWIND: begin
                if (r_pend) begin
                    tab_we = 1'b1;
                    tab_wa = r_trl_rd;
                end
                if (r_trail_len > r_keep) begin
                    trl_re      = 1'b1;
                    trl_ra      = AW'(r_trail_len - 1'b1);
                    n_trail_len = r_trail_len - 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    fin    = !r_pend;
                end
            end
            S_DEC_HEAD: begin
                if (r_hint_count == '0) begin
                    fin = 1'b1;
                end else begin
                    hq_re        = 1'b1;
                    hq_ra        = r_hint_head;
                    n_hint_head  = (r_hint_head == HW'(HINT_DEPTH - 1)) ? '0
                                                                       : r_hint_head + 1'b1;
                    n_hint_count = r_hint_count - 1'b1;
                    n_state      = S_DEC_VAR;
                end
            end
            S_DEC_VAR: begin
                tab_re  = 1'b1;
                tab_ra  = AW'(r_hq_rd[VAR_W:1]);
                n_state = S_DEC_CHK;
            end
            S_DEC_CHK: begin
                if (r_tab_rd == AV_OPEN) begin
                    fin            = 1'b1;
                    fin_res.dvalid = 1'b1;
                    fin_res.dvar   = r_hq_rd[VAR_W:1];
                    fin_res.dneg   = r_hq_rd[0];
                end else begin
                    n_state = S_DEC_HEAD;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (slot_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_trail_len   <= '0;
            r_level_count <= '0;
            r_hint_head   <= '0;
            r_hint_count  <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_trail_len   <= n_trail_len;
            r_level_count <= n_level_count;
            r_hint_head   <= n_hint_head;
            r_hint_count  <= n_hint_count;
            r_pend        <= n_pend;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_var  <= n_var;
        r_neg  <= n_neg;
        r_lvl  <= n_lvl;
        r_keep <= n_keep;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_decision_valid = r_out.dvalid;
    assign o_decision_var   = r_out.dvar;
    assign o_decision_neg   = r_out.dneg;
    assign o_status         = r_out.status;

endmodule

@@ hw/rtl/sdht_checker.sv @@
// ----------------------------------------------------------------------------
// sdht_checker
// port-level assertions for the trail tracker, bound to the tracker core
// ----------------------------------------------------------------------------
`include "sat_trail_decision_hint_tracker_core_macros.svh"

module sdht_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [sdht_pkg::CMD_W-1:0]  i_cmd,
    input logic [sdht_pkg::VAR_W-1:0]  i_lit_var,
    input logic                        i_lit_neg,
    input logic [sdht_pkg::LVL_W-1:0]  i_target_level,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_decision_valid,
    input logic [sdht_pkg::VAR_W-1:0]  o_decision_var,
    input logic                        o_decision_neg,
    input logic [sdht_pkg::ST_W-1:0]   o_status
);
    import sdht_pkg::*;

    logic                     in_take;
    logic                     out_stall;
    logic [VAR_W+ST_W+1:0]    out_bits;
    logic                     dec_idle;
    logic                     dec_ok;

    assign in_take   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_bits  = {o_decision_valid, o_decision_var, o_decision_neg, o_status};
    assign dec_idle  = (o_decision_var == '0) && !o_decision_neg;
    assign dec_ok    = (o_status == ST_OK) && (o_decision_var != '0);

    `SDHT_ASSERT_NXT(a_out_hold, out_stall, o_out_valid, "result dropped while stalled")
    `SDHT_ASSERT_NXT(a_out_stable, out_stall, $stable(out_bits), "result changed while stalled")
    `SDHT_ASSERT_IMP(a_no_decision_zero, o_out_valid && !o_decision_valid, dec_idle, "stray fields")
    `SDHT_ASSERT_IMP(a_decision_ok, o_out_valid && o_decision_valid, dec_ok, "bad decision result")
    `SDHT_ASSERT_NXT(a_one_item, in_take, !o_in_ready, "second item taken right after the first")

endmodule

bind sat_trail_decision_hint_tracker_core sdht_checker u_sdht_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_cmd            (i_cmd),
    .i_lit_var        (i_lit_var),
    .i_lit_neg        (i_lit_neg),
    .i_target_level   (i_target_level),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_decision_valid (o_decision_valid),
    .o_decision_var   (o_decision_var),
    .o_decision_neg   (o_decision_neg),
    .o_status         (o_status)
);
